### hw/rtl/i2cms_pkg.sv
// ----------------------------------------------------------------------------
// i2cms_pkg
// Types and codes shared by the I2C master interrupt sequencer modules.
// ----------------------------------------------------------------------------
package i2cms_pkg;

    // Operation codes of an input word.
    localparam logic [1:0] OP_START_TX = 2'd0;
    localparam logic [1:0] OP_START_RX = 2'd1;
    localparam logic [1:0] OP_EVENT    = 2'd2;
    localparam logic [1:0] OP_ERROR    = 2'd3;

    // Status codes.
    localparam logic [1:0] STATUS_GOOD      = 2'd0;
    localparam logic [1:0] STATUS_PARAM_ERR = 2'd1;
    localparam logic [1:0] STATUS_IN_USE    = 2'd2;

    // Transfer modes.
    localparam logic [1:0] MODE_READY = 2'd0;
    localparam logic [1:0] MODE_TX    = 2'd1;
    localparam logic [1:0] MODE_RX    = 2'd2;

    // Completion codes.
    localparam logic [1:0] DONE_NONE = 2'd0;
    localparam logic [1:0] DONE_TX   = 2'd1;
    localparam logic [1:0] DONE_RX   = 2'd2;

    // ACK level after reset.
    localparam logic ACK_DEFAULT_RESET = 1'b1;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] length;
        logic        repeated_start;
        logic        flag_addr;
        logic        flag_txe;
        logic        flag_rxne;
        logic        flag_btf;
        logic [4:0]  error_flags;
        logic [7:0]  tx_byte;
        logic [7:0]  rx_byte_first;
        logic [7:0]  rx_byte_second;
        logic [7:0]  rx_byte_third;
    } cmd_t;

    typedef struct packed {
        logic [1:0] status;
        logic       start_issued;
        logic       addr_cleared;
        logic       tx_write;
        logic [7:0] tx_byte_out;
        logic [1:0] rx_taken;
        logic       stop_issued;
        logic       ack_level;
        logic       pos_level;
        logic [1:0] done_event;
        logic [4:0] error_report;
    } rsp_t;

    typedef struct packed {
        logic ack_default;
    } cfg_t;

    // Pipeline control handed from the input stage to the core and result stage.
    typedef struct packed {
        logic valid;
        logic advance;
    } pipe_ctrl_t;

endpackage

### hw/rtl/i2cms_cmd_if.sv
// ----------------------------------------------------------------------------
// i2cms_cmd_if
// Valid/ready channel carrying request and event words into the sequencer.
// ----------------------------------------------------------------------------
interface i2cms_cmd_if;
    logic              valid;
    logic              ready;
    i2cms_pkg::cmd_t   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/i2cms_rsp_if.sv
// ----------------------------------------------------------------------------
// i2cms_rsp_if
// Valid/ready channel carrying result words out of the sequencer.
// ----------------------------------------------------------------------------
interface i2cms_rsp_if;
    logic              valid;
    logic              ready;
    i2cms_pkg::rsp_t   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/i2cms_cfg_if.sv
// ----------------------------------------------------------------------------
// i2cms_cfg_if
// Valid/ready write channel for the ACK default register.
// ----------------------------------------------------------------------------
interface i2cms_cfg_if;
    logic              valid;
    logic              ready;
    i2cms_pkg::cfg_t   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/i2cms_input_stage.sv
// ----------------------------------------------------------------------------
// i2cms_input_stage
// Input register: captures one word and holds it until the pipeline advances.
// ----------------------------------------------------------------------------
module i2cms_input_stage (
    input  logic                    clk,
    input  logic                    rst_n,
    i2cms_cmd_if.sink               cmd,
    input  logic                    advance,
    output i2cms_pkg::pipe_ctrl_t   ctrl,
    output i2cms_pkg::cmd_t         item
);

    logic              valid_reg;
    logic              valid_next;
    i2cms_pkg::cmd_t   item_reg;

    // A held word leaves when the result stage can take its result.
    assign cmd.ready  = !valid_reg || advance;
    assign valid_next = cmd.valid ? 1'b1 : (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            item_reg <= cmd.data;
        end
    end

    assign ctrl.valid   = valid_reg;
    assign ctrl.advance = advance;
    assign item         = item_reg;

endmodule

### hw/rtl/i2cms_core.sv
// ----------------------------------------------------------------------------
// i2cms_core
// Transfer state and the per-word decode that updates it and forms the result.
// ----------------------------------------------------------------------------
module i2cms_core #(
    parameter int LEN_WIDTH = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    i2cms_cfg_if.sink               cfg,
    input  i2cms_pkg::pipe_ctrl_t   ctrl,
    input  i2cms_pkg::cmd_t         item,
    output i2cms_pkg::rsp_t         result
);

    logic                  ack_default_reg;
    logic [1:0]            mode_reg;
    logic [1:0]            mode_next;
    logic [LEN_WIDTH-1:0]  left_reg;
    logic [LEN_WIDTH-1:0]  left_next;
    logic                  no_stop_reg;
    logic                  no_stop_next;
    logic                  ack_reg;
    logic                  ack_next;
    logic                  pos_reg;
    logic                  pos_next;
    logic                  err_en_reg;
    logic                  err_en_next;

    logic [LEN_WIDTH+15:0] len_ext;
    logic [LEN_WIDTH-1:0]  len;
    logic                  busy;
    logic                  fire;

    assign fire    = ctrl.valid && ctrl.advance;
    assign len_ext = {{LEN_WIDTH{1'b0}}, item.length};
    assign len     = len_ext[LEN_WIDTH-1:0];
    assign busy    = (mode_reg == i2cms_pkg::MODE_TX) || (mode_reg == i2cms_pkg::MODE_RX);

    assign cfg.ready = 1'b1;

    always_comb
    begin
        mode_next    = mode_reg;
        left_next    = left_reg;
        no_stop_next = no_stop_reg;
        ack_next     = ack_reg;
        pos_next     = pos_reg;
        err_en_next  = err_en_reg;
        result       = '0;

        priority if (item.operation == i2cms_pkg::OP_START_TX ||
                     item.operation == i2cms_pkg::OP_START_RX)
        begin
            priority if (len == '0)
            begin
                result.status = i2cms_pkg::STATUS_PARAM_ERR;
            end
            else if (busy)
            begin
                result.status = i2cms_pkg::STATUS_IN_USE;
            end
            else
            begin
                left_next    = len;
                no_stop_next = item.repeated_start;
                err_en_next  = 1'b1;
                result.start_issued = 1'b1;
                if (item.operation == i2cms_pkg::OP_START_TX)
                begin
                    mode_next = i2cms_pkg::MODE_TX;
                end
                else
                begin
                    mode_next = i2cms_pkg::MODE_RX;
                    pos_next  = 1'b0;
                end
            end
        end
        else if (item.operation == i2cms_pkg::OP_EVENT)
        begin
            if (mode_reg == i2cms_pkg::MODE_TX)
            begin
                result.addr_cleared = item.flag_addr;
                if (item.flag_txe && left_reg != '0)
                begin
                    result.tx_write    = 1'b1;
                    result.tx_byte_out = item.tx_byte;
                    left_next          = left_reg - LEN_WIDTH'(1);
                end
                if (left_next == '0 && item.flag_btf)
                begin
                    result.stop_issued = !no_stop_reg;
                    result.done_event  = i2cms_pkg::DONE_TX;
                    mode_next          = i2cms_pkg::MODE_READY;
                end
            end
            else if (mode_reg == i2cms_pkg::MODE_RX)
            begin
                if (item.flag_addr)
                begin
                    result.addr_cleared = 1'b1;
                    priority if (left_reg == LEN_WIDTH'(1))
                    begin
                        ack_next           = 1'b0;
                        result.stop_issued = !no_stop_reg;
                    end
                    else if (left_reg == LEN_WIDTH'(2))
                    begin
                        pos_next = 1'b1;
                        ack_next = 1'b0;
                    end
                    else
                    begin
                        ack_next = 1'b1;
                    end
                end
                if (item.flag_rxne && left_reg != '0)
                begin
                    result.rx_taken = 2'd1;
                    left_next       = left_reg - LEN_WIDTH'(1);
                    if (left_next == '0)
                    begin
                        mode_next         = i2cms_pkg::MODE_READY;
                        result.done_event = i2cms_pkg::DONE_RX;
                        if (ack_default_reg)
                        begin
                            ack_next = 1'b1;
                        end
                    end
                end
                // Two bytes wait in the shift and data registers: read both at once.
                if (item.flag_btf && mode_next == i2cms_pkg::MODE_RX &&
                    left_next == LEN_WIDTH'(2))
                begin
                    if (!no_stop_reg)
                    begin
                        result.stop_issued = 1'b1;
                    end
                    result.rx_taken   = result.rx_taken + 2'd2;
                    result.done_event = i2cms_pkg::DONE_RX;
                    pos_next          = 1'b0;
                    mode_next         = i2cms_pkg::MODE_READY;
                    left_next         = '0;
                    if (ack_default_reg)
                    begin
                        ack_next = 1'b1;
                    end
                end
            end
        end
        else
        begin
            if (err_en_reg)
            begin
                result.error_report = item.error_flags;
            end
        end

        result.ack_level = ack_next;
        result.pos_level = pos_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ack_default_reg <= i2cms_pkg::ACK_DEFAULT_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            ack_default_reg <= cfg.data.ack_default;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= i2cms_pkg::MODE_READY;
            left_reg    <= '0;
            no_stop_reg <= 1'b0;
            ack_reg     <= i2cms_pkg::ACK_DEFAULT_RESET;
            pos_reg     <= 1'b0;
            err_en_reg  <= 1'b0;
        end
        else if (fire)
        begin
            mode_reg    <= mode_next;
            left_reg    <= left_next;
            no_stop_reg <= no_stop_next;
            ack_reg     <= ack_next;
            pos_reg     <= pos_next;
            err_en_reg  <= err_en_next;
        end
    end

endmodule

### hw/rtl/i2cms_output_stage.sv
// ----------------------------------------------------------------------------
// i2cms_output_stage
// Result register: holds one result word until the downstream side takes it.
// ----------------------------------------------------------------------------
module i2cms_output_stage (
    input  logic                    clk,
    input  logic                    rst_n,
    input  i2cms_pkg::pipe_ctrl_t   ctrl,
    input  i2cms_pkg::rsp_t         result,
    output logic                    advance,
    i2cms_rsp_if.source             rsp
);

    logic              valid_reg;
    i2cms_pkg::rsp_t   data_reg;

    // The register is free when empty or when its word is taken this cycle.
    assign advance = !valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= ctrl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && ctrl.valid)
        begin
            data_reg <= result;
        end
    end

    assign rsp.valid = valid_reg;
    assign rsp.data  = data_reg;

endmodule

### hw/rtl/i2c_master_interrupt_sequencer.sv
// ----------------------------------------------------------------------------
// i2c_master_interrupt_sequencer
// Interrupt-driven I2C master transfer sequencer with one result per word.
// ----------------------------------------------------------------------------
// Each word on cmd (a start-transmit or start-receive request, an event
// snapshot or an error snapshot) yields exactly one result word on rsp. A word
// is registered on entry, decoded against the transfer state and its result
// registered, so the block takes one word per clock while rsp is not stalled;
// each result word waits in the result register until rsp takes it. The rate is
// set by the single decode stage between the input and result registers; a
// stalled rsp holds the pipeline. The ACK default register on cfg is always
// ready and should be written only while no word is in flight.
// ----------------------------------------------------------------------------
module i2c_master_interrupt_sequencer #(
    parameter int LEN_WIDTH = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    i2cms_cmd_if.sink    cmd,
    i2cms_rsp_if.source  rsp,
    i2cms_cfg_if.sink    cfg
);

    i2cms_pkg::pipe_ctrl_t  ctrl;
    i2cms_pkg::cmd_t        item;
    i2cms_pkg::rsp_t        result;
    logic                   advance;

    i2cms_input_stage u_input_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .advance (advance),
        .ctrl    (ctrl),
        .item    (item)
    );

    i2cms_core #(
        .LEN_WIDTH (LEN_WIDTH)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .ctrl   (ctrl),
        .item   (item),
        .result (result)
    );

    i2cms_output_stage u_output_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .result  (result),
        .advance (advance),
        .rsp     (rsp)
    );

endmodule

### bench/i2cms_scoreboard.sv
// ----------------------------------------------------------------------------
// i2cms_scoreboard
// Watches the cmd, rsp and cfg channels of the I2C master sequencer, predicts
// the result of every accepted word and compares it with the result words.
// ----------------------------------------------------------------------------
module i2cms_scoreboard (
    input  logic  clk,
    input  logic  rst_n,
    i2cms_cmd_if  cmd,
    i2cms_rsp_if  rsp,
    i2cms_cfg_if  cfg,
    output int    mismatches,
    output int    in_flight,
    output int    results_seen,
    output int    transfers_done
);

    localparam int REPORT_LIMIT = 10;

    // Transfer state as the bus software would see it.
    logic [1:0]  xfer_mode;
    logic [15:0] bytes_to_go;
    logic        hold_bus;
    logic        ack_ctl;
    logic        pos_ctl;
    logic        err_armed;
    logic        ack_restore;

    i2cms_pkg::rsp_t expected_rsp[$];
    int   fail_count;
    int   result_count;
    int   done_count;

    function automatic void close_receive();
        xfer_mode   = i2cms_pkg::MODE_READY;
        bytes_to_go = '0;
        if (ack_restore)
            ack_ctl = 1'b1;
    endfunction

    function automatic i2cms_pkg::rsp_t sequence_word(input i2cms_pkg::cmd_t w);
        i2cms_pkg::rsp_t r;
        logic busy;
        r    = '0;
        busy = (xfer_mode == i2cms_pkg::MODE_TX) || (xfer_mode == i2cms_pkg::MODE_RX);
        case (w.operation)
            i2cms_pkg::OP_START_TX, i2cms_pkg::OP_START_RX:
            begin
                // A zero length is rejected even while a transfer runs.
                if (w.length == '0)
                    r.status = i2cms_pkg::STATUS_PARAM_ERR;
                else if (busy)
                    r.status = i2cms_pkg::STATUS_IN_USE;
                else
                begin
                    bytes_to_go = w.length;
                    hold_bus    = w.repeated_start;
                    xfer_mode   = (w.operation == i2cms_pkg::OP_START_TX) ?
                                  i2cms_pkg::MODE_TX : i2cms_pkg::MODE_RX;
                    if (w.operation == i2cms_pkg::OP_START_RX)
                        pos_ctl = 1'b0;
                    r.start_issued = 1'b1;
                    err_armed      = 1'b1;
                end
            end
            i2cms_pkg::OP_EVENT:
            begin
                if (xfer_mode == i2cms_pkg::MODE_TX)
                begin
                    r.addr_cleared = w.flag_addr;
                    if (w.flag_txe && bytes_to_go != '0)
                    begin
                        r.tx_write    = 1'b1;
                        r.tx_byte_out = w.tx_byte;
                        bytes_to_go   = bytes_to_go - 16'd1;
                    end
                    if (bytes_to_go == '0 && w.flag_btf)
                    begin
                        if (!hold_bus)
                            r.stop_issued = 1'b1;
                        xfer_mode    = i2cms_pkg::MODE_READY;
                        r.done_event = i2cms_pkg::DONE_TX;
                    end
                end
                else if (xfer_mode == i2cms_pkg::MODE_RX)
                begin
                    if (w.flag_addr)
                    begin
                        r.addr_cleared = 1'b1;
                        if (bytes_to_go == 16'd1)
                        begin
                            ack_ctl = 1'b0;
                            if (!hold_bus)
                                r.stop_issued = 1'b1;
                        end
                        else if (bytes_to_go == 16'd2)
                        begin
                            pos_ctl = 1'b1;
                            ack_ctl = 1'b0;
                        end
                        else
                            ack_ctl = 1'b1;
                    end
                    if (w.flag_rxne && bytes_to_go != '0)
                    begin
                        r.rx_taken  = 2'd1;
                        bytes_to_go = bytes_to_go - 16'd1;
                        if (bytes_to_go == '0)
                        begin
                            close_receive();
                            r.done_event = i2cms_pkg::DONE_RX;
                        end
                    end
                    // With two bytes left a finished byte means both sit in the
                    // shift and data registers and are read together.
                    if (w.flag_btf && xfer_mode == i2cms_pkg::MODE_RX &&
                        bytes_to_go == 16'd2)
                    begin
                        if (!hold_bus)
                            r.stop_issued = 1'b1;
                        r.rx_taken = r.rx_taken + 2'd2;
                        pos_ctl    = 1'b0;
                        close_receive();
                        r.done_event = i2cms_pkg::DONE_RX;
                    end
                end
            end
            default:
            begin
                if (err_armed)
                    r.error_report = w.error_flags;
            end
        endcase
        r.ack_level = ack_ctl;
        r.pos_level = pos_ctl;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track_words
        i2cms_pkg::rsp_t want;
        string           wrong;
        if (!rst_n)
        begin
            xfer_mode    = i2cms_pkg::MODE_READY;
            bytes_to_go  = '0;
            hold_bus     = 1'b0;
            ack_restore  = i2cms_pkg::ACK_DEFAULT_RESET;
            ack_ctl      = i2cms_pkg::ACK_DEFAULT_RESET;
            pos_ctl      = 1'b0;
            err_armed    = 1'b0;
            fail_count   = 0;
            result_count = 0;
            done_count   = 0;
            expected_rsp.delete();
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                ack_restore = cfg.data.ack_default;
            if (rsp.valid && rsp.ready)
            begin
                result_count++;
                if (expected_rsp.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("result word %0d arrived with none expected: %p",
                                 result_count, rsp.data);
                end
                else
                begin
                    want  = expected_rsp.pop_front();
                    wrong = "";
                    if (rsp.data.status !== want.status)             wrong = {wrong, " status"};
                    if (rsp.data.start_issued !== want.start_issued) wrong = {wrong, " start"};
                    if (rsp.data.addr_cleared !== want.addr_cleared) wrong = {wrong, " addr"};
                    if (rsp.data.tx_write !== want.tx_write)         wrong = {wrong, " tx_write"};
                    if (rsp.data.tx_byte_out !== want.tx_byte_out)   wrong = {wrong, " tx_byte"};
                    if (rsp.data.rx_taken !== want.rx_taken)         wrong = {wrong, " rx_taken"};
                    if (rsp.data.stop_issued !== want.stop_issued)   wrong = {wrong, " stop"};
                    if (rsp.data.ack_level !== want.ack_level)       wrong = {wrong, " ack"};
                    if (rsp.data.pos_level !== want.pos_level)       wrong = {wrong, " pos"};
                    if (rsp.data.done_event !== want.done_event)     wrong = {wrong, " done"};
                    if (rsp.data.error_report !== want.error_report) wrong = {wrong, " errors"};
                    if (wrong != "")
                    begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                            $display("result word %0d mismatch in%s: expected %p, got %p",
                                     result_count, wrong, want, rsp.data);
                    end
                end
            end
            if (cmd.valid && cmd.ready)
            begin
                want = sequence_word(cmd.data);
                if (want.done_event != i2cms_pkg::DONE_NONE)
                    done_count++;
                expected_rsp.push_back(want);
            end
        end
        mismatches     <= fail_count;
        in_flight      <= expected_rsp.size();
        results_seen   <= result_count;
        transfers_done <= done_count;
    end

endmodule

### bench/i2c_master_interrupt_sequencer_tb.sv
// ----------------------------------------------------------------------------
// i2c_master_interrupt_sequencer_tb
// Drives start requests, event and error snapshots into the sequencer with
// bursty traffic and a stalling result side, changes the ACK default between
// phases and takes the verdict from the scoreboard.
// ----------------------------------------------------------------------------
module i2c_master_interrupt_sequencer_tb;

    localparam int RANDOM_UNTIL   = 1780;
    localparam int CFG_PHASE      = 300;
    localparam int LONG_TAIL      = 60;
    localparam int SETTLE_CYCLES  = 6;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PATTERN, STALL_HEAVY} stall_style_t;

    logic clk;
    logic rst_n;

    i2cms_cmd_if cmd_ch ();
    i2cms_rsp_if rsp_ch ();
    i2cms_cfg_if cfg_ch ();

    int mismatches;
    int in_flight;
    int results_seen;
    int transfers_done;

    i2c_master_interrupt_sequencer dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    i2cms_scoreboard board (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd_ch),
        .rsp            (rsp_ch),
        .cfg            (cfg_ch),
        .mismatches     (mismatches),
        .in_flight      (in_flight),
        .results_seen   (results_seen),
        .transfers_done (transfers_done)
    );

    // Rough view of the transfer in progress, used only to shape the stimulus.
    logic plan_busy;
    logic plan_tx;
    logic plan_fresh;
    int   plan_rem;

    int   burst_left;
    int   sent;
    int   n_tx_start;
    int   n_rx_start;
    int   n_event;
    int   n_error;
    int   n_cfg;
    logic ack_setting;
    int   idle_cycles = 0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic i2cms_pkg::cmd_t random_word();
        logic [63:0] bits;
        bits = {$urandom, $urandom};
        return bits[$bits(i2cms_pkg::cmd_t)-1:0];
    endfunction

    function automatic i2cms_pkg::cmd_t make_word(input logic [1:0] op,
                                                  input logic [15:0] len,
                                                  input logic rs);
        i2cms_pkg::cmd_t w;
        w = '0;
        w.operation      = op;
        w.length         = len;
        w.repeated_start = rs;
        return w;
    endfunction

    function automatic i2cms_pkg::cmd_t event_word(input logic addr, input logic txe,
                                                   input logic rxne, input logic btf,
                                                   input logic [7:0] txb);
        i2cms_pkg::cmd_t w;
        w = make_word(i2cms_pkg::OP_EVENT, '0, 1'b0);
        w.flag_addr      = addr;
        w.flag_txe       = txe;
        w.flag_rxne      = rxne;
        w.flag_btf       = btf;
        w.tx_byte        = txb;
        w.rx_byte_first  = ~txb;
        w.rx_byte_second = txb;
        w.rx_byte_third  = ~txb;
        return w;
    endfunction

    function automatic i2cms_pkg::cmd_t error_word(input logic [4:0] flags);
        i2cms_pkg::cmd_t w;
        w = make_word(i2cms_pkg::OP_ERROR, '0, 1'b0);
        w.error_flags = flags;
        return w;
    endfunction

    // An event that moves the current transfer along, with random payload.
    function automatic i2cms_pkg::cmd_t progress_event();
        i2cms_pkg::cmd_t w;
        w = random_word();
        w.operation = i2cms_pkg::OP_EVENT;
        w.flag_addr = plan_fresh || ($urandom_range(0, 9) == 0);
        if (plan_tx)
        begin
            w.flag_txe = (plan_rem > 0) ? ($urandom_range(0, 9) < 8)
                                        : 1'($urandom_range(0, 1));
            w.flag_btf = (plan_rem > 0) ? ($urandom_range(0, 5) == 0)
                                        : 1'($urandom_range(0, 1));
        end
        else
        begin
            w.flag_rxne = plan_fresh ? ($urandom_range(0, 4) == 0) : ($urandom_range(0, 9) < 6);
            w.flag_btf  = ($urandom_range(0, 2) == 0);
        end
        return w;
    endfunction

    // Anything at all, except that an idle block never gets a nonzero length,
    // which could start a transfer far too long to finish.
    function automatic i2cms_pkg::cmd_t noise_word();
        i2cms_pkg::cmd_t w;
        w = random_word();
        w.operation = 2'($urandom_range(0, 3));
        if ((w.operation == i2cms_pkg::OP_START_TX || w.operation == i2cms_pkg::OP_START_RX)
            && (!plan_busy || $urandom_range(0, 3) == 0))
            w.length = '0;
        return w;
    endfunction

    task automatic send_word(input i2cms_pkg::cmd_t w);
        if (burst_left == 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        cmd_ch.valid <= 1'b1;
        cmd_ch.data  <= w;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        sent++;
        case (w.operation)
            i2cms_pkg::OP_START_TX: n_tx_start++;
            i2cms_pkg::OP_START_RX: n_rx_start++;
            i2cms_pkg::OP_EVENT:    n_event++;
            default:                n_error++;
        endcase
        if ((w.operation == i2cms_pkg::OP_START_TX || w.operation == i2cms_pkg::OP_START_RX)
            && w.length != '0 && !plan_busy)
        begin
            plan_busy  = 1'b1;
            plan_tx    = (w.operation == i2cms_pkg::OP_START_TX);
            plan_rem   = int'(w.length);
            plan_fresh = 1'b1;
        end
        else if (w.operation == i2cms_pkg::OP_EVENT && plan_busy)
        begin
            plan_fresh = 1'b0;
            if (plan_tx)
            begin
                if (w.flag_txe && plan_rem > 0)
                    plan_rem--;
                if (plan_rem == 0 && w.flag_btf)
                    plan_busy = 1'b0;
            end
            else
            begin
                if (w.flag_rxne && plan_rem > 0)
                begin
                    plan_rem--;
                    if (plan_rem == 0)
                        plan_busy = 1'b0;
                end
                if (plan_busy && w.flag_btf && plan_rem == 2)
                    plan_busy = 1'b0;
            end
        end
    endtask

    // Hold the sender until every result is back, then give the block time.
    task automatic wait_drained();
        cmd_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (in_flight != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_ack_default(input logic value);
        wait_drained();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= '{ack_default: value};
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        ack_setting = value;
        n_cfg++;
    endtask

    // Result side: stalls in styles that are chosen anew at random.
    initial
    begin
        stall_style_t style;
        int           style_left;
        logic [7:0]   rot;
        rsp_ch.ready <= 1'b0;
        style_left = 0;
        style      = STALL_NONE;
        rot        = 8'b1011_0010;
        forever
        begin
            @(posedge clk);
            if (style_left == 0)
            begin
                style      = stall_style_t'($urandom_range(0, 3));
                style_left = $urandom_range(16, 96);
            end
            style_left--;
            rot = {rot[6:0], rot[7]};
            case (style)
                STALL_NONE:    rsp_ch.ready <= 1'b1;
                STALL_RANDOM:  rsp_ch.ready <= ($urandom_range(0, 3) != 0);
                STALL_PATTERN: rsp_ch.ready <= rot[0];
                default:       rsp_ch.ready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no word moved for %0d cycles, %0d results outstanding",
                     idle_cycles, in_flight);
            $display("FAILURE");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        i2cms_pkg::cmd_t w;
        int              next_cfg_at;
        rst_n        <= 1'b0;
        cmd_ch.valid <= 1'b0;
        cmd_ch.data  <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.data  <= '0;
        plan_busy  = 1'b0;
        plan_tx    = 1'b0;
        plan_fresh = 1'b0;
        plan_rem   = 0;
        burst_left = 0;
        sent       = 0;
        n_tx_start = 0;
        n_rx_start = 0;
        n_event    = 0;
        n_error    = 0;
        n_cfg      = 0;
        ack_setting = i2cms_pkg::ACK_DEFAULT_RESET;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Idle block: errors are ignored before any start, events do nothing,
        // and a zero length is refused.
        send_word(error_word(5'h1F));
        send_word(event_word(1'b1, 1'b1, 1'b1, 1'b1, 8'hFF));
        send_word(make_word(i2cms_pkg::OP_START_TX, 16'h0000, 1'b1));
        send_word(make_word(i2cms_pkg::OP_START_RX, 16'h0000, 1'b0));
        // One-byte transmit; starts while busy are refused, zero length first.
        send_word(make_word(i2cms_pkg::OP_START_TX, 16'h0001, 1'b0));
        send_word(make_word(i2cms_pkg::OP_START_RX, 16'hFFFF, 1'b1));
        send_word(make_word(i2cms_pkg::OP_START_TX, 16'h0000, 1'b0));
        send_word(event_word(1'b1, 1'b1, 1'b0, 1'b0, 8'hFF));
        send_word(event_word(1'b0, 1'b1, 1'b0, 1'b0, 8'h00));
        send_word(event_word(1'b0, 1'b0, 1'b0, 1'b1, 8'h00));
        send_word(error_word(5'h1F));
        send_word(error_word(5'h00));

        // Receives of one and two bytes with ACK left off afterwards.
        write_ack_default(1'b0);
        send_word(make_word(i2cms_pkg::OP_START_RX, 16'h0001, 1'b0));
        send_word(event_word(1'b1, 1'b0, 1'b0, 1'b0, 8'h3C));
        send_word(event_word(1'b0, 1'b0, 1'b1, 1'b0, 8'hC3));
        send_word(make_word(i2cms_pkg::OP_START_RX, 16'h0002, 1'b1));
        send_word(event_word(1'b1, 1'b0, 1'b0, 1'b0, 8'h81));
        send_word(event_word(1'b0, 1'b0, 1'b0, 1'b1, 8'h7E));

        // Longer receive finishing with three bytes in one word, then a
        // two-byte transmit with repeated start.
        write_ack_default(1'b1);
        send_word(make_word(i2cms_pkg::OP_START_RX, 16'h0003, 1'b0));
        send_word(event_word(1'b1, 1'b0, 1'b0, 1'b0, 8'h11));
        send_word(event_word(1'b0, 1'b0, 1'b1, 1'b1, 8'hEE));
        send_word(make_word(i2cms_pkg::OP_START_TX, 16'h0002, 1'b1));
        send_word(event_word(1'b1, 1'b1, 1'b1, 1'b0, 8'h5A));
        send_word(event_word(1'b0, 1'b1, 1'b0, 1'b1, 8'hA5));

        next_cfg_at = sent + CFG_PHASE;
        while (sent < RANDOM_UNTIL || plan_busy)
        begin
            if (sent >= next_cfg_at)
            begin
                write_ack_default(~ack_setting);
                next_cfg_at = sent + CFG_PHASE;
            end
            if ($urandom_range(0, 9) == 0)
                send_word(noise_word());
            else if (plan_busy)
                send_word(progress_event());
            else
            begin
                w = random_word();
                w.operation = $urandom_range(0, 1) ? i2cms_pkg::OP_START_RX
                                                   : i2cms_pkg::OP_START_TX;
                case ($urandom_range(0, 9))
                    0, 1:       w.length = 16'd1;
                    2, 3:       w.length = 16'd2;
                    4:          w.length = 16'd3;
                    5, 6, 7, 8: w.length = 16'($urandom_range(4, 10));
                    default:    w.length = 16'($urandom_range(11, 48));
                endcase
                send_word(w);
            end
        end

        // A transfer of the largest length, left running at the end.
        w = random_word();
        w.operation = $urandom_range(0, 1) ? i2cms_pkg::OP_START_RX : i2cms_pkg::OP_START_TX;
        w.length    = 16'hFFFF;
        send_word(w);
        repeat (LONG_TAIL)
        begin
            if ($urandom_range(0, 4) == 0)
                send_word(noise_word());
            else
                send_word(progress_event());
        end

        wait_drained();
        $display("Sent %0d words: %0d transmit starts, %0d receive starts,",
                 sent, n_tx_start, n_rx_start);
        $display("%0d events, %0d error snapshots.", n_event, n_error);
        $display("Checked %0d results, %0d completed transfers, ACK default written %0d times.",
                 results_seen, transfers_done, n_cfg);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### sim.f
hw/rtl/i2cms_pkg.sv
hw/rtl/i2cms_cmd_if.sv
hw/rtl/i2cms_rsp_if.sv
hw/rtl/i2cms_cfg_if.sv
hw/rtl/i2cms_input_stage.sv
hw/rtl/i2cms_core.sv
hw/rtl/i2cms_output_stage.sv
hw/rtl/i2c_master_interrupt_sequencer.sv
bench/i2cms_scoreboard.sv
bench/i2c_master_interrupt_sequencer_tb.sv
